/* hw/rtl/psa_pkg.sv */
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants for the pairwise sequence alignment block.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned MaxLenDefault = 32;

  // input item codes
  localparam logic [1:0] MODE_LOAD_V = 2'd0;
  localparam logic [1:0] MODE_LOAD_H = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MATCH    = 2'd0;
  localparam logic [1:0] CFG_MISMATCH = 2'd1;
  localparam logic [1:0] CFG_GAP      = 2'd2;
  localparam logic [1:0] CFG_LOCAL    = 2'd3;

  // traceback step codes
  localparam logic [1:0] PTR_STOP = 2'd0;
  localparam logic [1:0] PTR_DIAG = 2'd1;
  localparam logic [1:0] PTR_LEFT = 2'd2;
  localparam logic [1:0] PTR_UP   = 2'd3;

  localparam logic [7:0] GAP_CHAR = 8'd45;
  localparam int unsigned ScoreOutW = 14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DRAIN,
    ST_TINIT,
    ST_TRD,
    ST_TEV,
    ST_EINIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load_v;
    logic load_h;
    logic fill_init;
    logic fill_issue;
    logic trace_init;
    logic trace_rd;
    logic trace_ev;
    logic emit_init;
    logic emit_issue;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic trace_origin;
    logic trace_stop;
    logic emit_last;
  } sts_t;

  typedef struct packed {
    logic [7:0] vch;
    logic [7:0] hch;
    logic       same;
  } col_t;

endpackage

/* hw/rtl/psa_ctrl.sv */
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer for load, matrix fill, traceback and column emission.
// ----------------------------------------------------------------------------
module psa_ctrl import psa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] mode_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && mode_i == MODE_START) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (sts_i.fill_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_TINIT;
      ST_TINIT: state_d = ST_TRD;
      ST_TRD: begin
        state_d = sts_i.trace_origin ? ST_EINIT : ST_TEV;
      end
      ST_TEV: begin
        state_d = sts_i.trace_stop ? ST_EINIT : ST_TRD;
      end
      ST_EINIT: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        cmd_o.load_v = start_i && mode_i == MODE_LOAD_V;
        cmd_o.load_h = start_i && mode_i == MODE_LOAD_H;
        cmd_o.fill_init = start_i && mode_i == MODE_START;
      end
      ST_FILL:  cmd_o.fill_issue = 1'b1;
      ST_DRAIN: ;
      ST_TINIT: cmd_o.trace_init = 1'b1;
      ST_TRD:   cmd_o.trace_rd = !sts_i.trace_origin;
      ST_TEV:   cmd_o.trace_ev = 1'b1;
      ST_EINIT: cmd_o.emit_init = 1'b1;
      ST_EMIT:  cmd_o.emit_issue = 1'b1;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/psa_dp.sv */
// ----------------------------------------------------------------------------
// psa_dp
// Sequence stores, score row, pointer matrix, column buffer and cell unit.
// ----------------------------------------------------------------------------
module psa_dp import psa_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  input  logic [7:0]                  symbol_i,
  input  logic                        cfg_valid_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  output logic                        result_strobe_o,
  output logic [7:0]                  vertical_char_o,
  output logic [7:0]                  horizontal_char_o,
  output logic                        is_match_o,
  output logic                        column_valid_o,
  output logic signed [ScoreOutW-1:0] total_score_o,
  output logic                        last_column_o
);

  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned PD  = (MAX_LEN + 1) * (MAX_LEN + 1);
  localparam int unsigned PAW = $clog2(PD);
  localparam int unsigned CD  = 2 * MAX_LEN;
  localparam int unsigned CAW = $clog2(CD);
  localparam int unsigned NW  = $clog2(CD + 1);
  localparam int unsigned SW  = $clog2(512 * MAX_LEN + 1) + 1;

  // configuration
  logic signed [7:0] match_q, mismatch_q, gap_q;
  logic              local_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q    <= 8'sd1;
      mismatch_q <= -8'sd1;
      gap_q      <= -8'sd2;
      local_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MATCH:    match_q    <= cfg_data_i;
        CFG_MISMATCH: mismatch_q <= cfg_data_i;
        CFG_GAP:      gap_q      <= cfg_data_i;
        CFG_LOCAL:    local_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // memories
  logic [7:0]          vmem [MAX_LEN];
  logic [7:0]          hmem [MAX_LEN];
  logic signed [SW-1:0] rmem [MAX_LEN+1];
  logic [1:0]          pmem [PD];
  col_t                cmem [CD];

  logic [LW-1:0] vlen_q, hlen_q;
  logic [LW-1:0] fr_q, fc_q, tr_q, tc_q;
  logic [LW-1:0] s1_r_q, s1_c_q, best_r_q, best_c_q;
  logic          s1_valid_q, byp_q;
  logic signed [SW-1:0] byp_val_q, diag_q, left_q, best_q, last_q, rrd_q;
  logic [7:0]    vrd_q, hrd_q;
  logic [1:0]    prd_q;
  logic [NW-1:0] n_q, e_q;
  col_t          crd_q;
  logic          o_strobe_q, o_last_q, o_colv_q;
  logic signed [ScoreOutW-1:0] score_q;

  logic [LW-1:0] vaddr, haddr;
  logic          vrd_en, hrd_en;

  assign vaddr  = cmd_i.fill_issue ? fr_q - LW'(1) : tr_q - LW'(1);
  assign haddr  = cmd_i.fill_issue ? fc_q - LW'(1) : tc_q - LW'(1);
  assign vrd_en = (cmd_i.fill_issue && fc_q == '0) || cmd_i.trace_rd;
  assign hrd_en = cmd_i.fill_issue || cmd_i.trace_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_v && vlen_q < LW'(MAX_LEN)) vmem[vlen_q[AW-1:0]] <= symbol_i;
    if (cmd_i.load_h && hlen_q < LW'(MAX_LEN)) hmem[hlen_q[AW-1:0]] <= symbol_i;
    if (vrd_en) vrd_q <= vmem[vaddr[AW-1:0]];
    if (hrd_en) hrd_q <= hmem[haddr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= '0;
      hlen_q <= '0;
    end else if (cmd_i.emit_init) begin
      vlen_q <= '0;
      hlen_q <= '0;
    end else begin
      if (cmd_i.load_v && vlen_q < LW'(MAX_LEN)) vlen_q <= vlen_q + LW'(1);
      if (cmd_i.load_h && hlen_q < LW'(MAX_LEN)) hlen_q <= hlen_q + LW'(1);
    end
  end

  // cell unit
  logic signed [SW-1:0] up, ds, us, ls, mx, cur;
  logic [1:0]           ptr;
  logic                 eq;

  always_comb begin
    up  = byp_q ? byp_val_q : rrd_q;
    eq  = vrd_q == hrd_q;
    ds  = diag_q + (eq ? SW'(match_q) : SW'(mismatch_q));
    us  = up + SW'(gap_q);
    ls  = left_q + SW'(gap_q);
    mx  = ds;
    if (us > mx) mx = us;
    if (ls > mx) mx = ls;
    if (s1_r_q == '0 || s1_c_q == '0) begin
      if (local_q || (s1_r_q == '0 && s1_c_q == '0)) begin
        cur = '0;
        ptr = PTR_STOP;
      end else if (s1_r_q == '0) begin
        cur = ls;
        ptr = PTR_LEFT;
      end else begin
        cur = us;
        ptr = PTR_UP;
      end
    end else begin
      cur = (local_q && mx < 0) ? '0 : mx;
      if (local_q && cur == '0) ptr = PTR_STOP;
      else if (ds == cur)       ptr = PTR_DIAG;
      else if (us == cur)       ptr = PTR_UP;
      else                      ptr = PTR_LEFT;
    end
  end

  logic [PAW-1:0] s1_paddr, tr_paddr;
  assign s1_paddr = PAW'(s1_r_q) * PAW'(MAX_LEN + 1) + PAW'(s1_c_q);
  assign tr_paddr = PAW'(tr_q) * PAW'(MAX_LEN + 1) + PAW'(tc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_issue) rrd_q <= rmem[fc_q];
    if (s1_valid_q) begin
      rmem[s1_c_q]   <= cur;
      pmem[s1_paddr] <= ptr;
      left_q         <= cur;
      diag_q         <= up;
      last_q         <= cur;
    end
    byp_q     <= s1_valid_q && s1_c_q == fc_q;
    byp_val_q <= cur;
    if (cmd_i.trace_rd) prd_q <= pmem[tr_paddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.fill_issue;
    end
  end

  // fill sequencing and best cell
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_init) begin
      fr_q     <= '0;
      fc_q     <= '0;
      best_q   <= '0;
      best_r_q <= '0;
      best_c_q <= '0;
    end else begin
      if (cmd_i.fill_issue) begin
        s1_r_q <= fr_q;
        s1_c_q <= fc_q;
        if (fc_q == hlen_q) begin
          fc_q <= '0;
          fr_q <= fr_q + LW'(1);
        end else begin
          fc_q <= fc_q + LW'(1);
        end
      end
      if (s1_valid_q && local_q && s1_r_q != '0 && s1_c_q != '0 && cur > best_q) begin
        best_q   <= cur;
        best_r_q <= s1_r_q;
        best_c_q <= s1_c_q;
      end
    end
  end

  // traceback
  col_t col;
  logic signed [31:0] sc32;

  always_comb begin
    col.vch  = vrd_q;
    col.hch  = hrd_q;
    col.same = eq;
    if (prd_q == PTR_LEFT) begin
      col.vch  = GAP_CHAR;
      col.same = 1'b0;
    end else if (prd_q == PTR_UP) begin
      col.hch  = GAP_CHAR;
      col.same = 1'b0;
    end
    sc32 = local_q ? 32'(best_q) : 32'(last_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.trace_init) begin
      tr_q <= local_q ? best_r_q : vlen_q;
      tc_q <= local_q ? best_c_q : hlen_q;
      n_q  <= '0;
      if (sc32 > 32'sd8191)       score_q <= 14'sd8191;
      else if (sc32 < -32'sd8192) score_q <= -14'sd8192;
      else                        score_q <= sc32[ScoreOutW-1:0];
    end else if (cmd_i.trace_ev && prd_q != PTR_STOP) begin
      cmem[n_q[CAW-1:0]] <= col;
      n_q <= n_q + NW'(1);
      if (prd_q != PTR_LEFT) tr_q <= tr_q - LW'(1);
      if (prd_q != PTR_UP)   tc_q <= tc_q - LW'(1);
    end
    if (cmd_i.emit_init) e_q <= n_q - NW'(1);
    if (cmd_i.emit_issue) begin
      crd_q    <= cmem[e_q[CAW-1:0]];
      e_q      <= e_q - NW'(1);
      o_last_q <= sts_o.emit_last;
      o_colv_q <= n_q != '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_strobe_q <= 1'b0;
    end else begin
      o_strobe_q <= cmd_i.emit_issue;
    end
  end

  assign sts_o.fill_last    = fr_q == vlen_q && fc_q == hlen_q;
  assign sts_o.trace_origin = tr_q == '0 && tc_q == '0;
  assign sts_o.trace_stop   = prd_q == PTR_STOP;
  assign sts_o.emit_last    = n_q == '0 || e_q == '0;

  assign result_strobe_o   = o_strobe_q;
  assign vertical_char_o   = o_colv_q ? crd_q.vch : 8'd0;
  assign horizontal_char_o = o_colv_q ? crd_q.hch : 8'd0;
  assign is_match_o        = o_colv_q && crd_q.same;
  assign column_valid_o    = o_colv_q;
  assign total_score_o     = score_q;
  assign last_column_o     = o_last_q;

endmodule

/* hw/rtl/pairwise_sequence_alignment_top.sv */
// ----------------------------------------------------------------------------
// pairwise_sequence_alignment_top
// Global or local pairwise alignment with linear gap cost.
// ----------------------------------------------------------------------------
// usage:
//   start with mode_i 0/1 appends symbol_i to the vertical/horizontal
//   sequence; busy stays low. Symbols past MAX_LEN are dropped.
//   start with mode_i 2 aligns the loaded sequences; busy is high until
//   the last column has been issued.
//   Configuration is written over cfg_valid_i/cfg_index_i/cfg_data_i while
//   idle; cfg_ready_o is always high.
//   phases for lengths V and H with N traced columns:
//     fill   all (V+1)*(H+1) cells, one cell per cycle through the score row
//     trace  a pointer read state and an evaluate state for each traced column
//     emit   one column per cycle in forward order, a single empty one if N = 0
//   Each column is shown for one cycle with result_strobe_o; the receiver
//   cannot stall. Reset clears the lengths and restores default scores.
// ----------------------------------------------------------------------------
module pairwise_sequence_alignment_top import psa_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode_i,
  input  logic [7:0]                  symbol_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  output logic                        result_strobe_o,
  output logic [7:0]                  vertical_char_o,
  output logic [7:0]                  horizontal_char_o,
  output logic                        is_match_o,
  output logic                        column_valid_o,
  output logic signed [ScoreOutW-1:0] total_score_o,
  output logic                        last_column_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  psa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mode_i (mode_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  psa_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .symbol_i         (symbol_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_strobe_o  (result_strobe_o),
    .vertical_char_o  (vertical_char_o),
    .horizontal_char_o(horizontal_char_o),
    .is_match_o       (is_match_o),
    .column_valid_o   (column_valid_o),
    .total_score_o    (total_score_o),
    .last_column_o    (last_column_o)
  );

endmodule

/* hw/rtl/psa_checker.sv */
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks for the alignment block, bound to the top level.
// ----------------------------------------------------------------------------
module psa_checker import psa_pkg::*; (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  mode_i,
  input logic                        result_strobe_o,
  input logic [7:0]                  vertical_char_o,
  input logic                        column_valid_o,
  input logic                        last_column_o
);

  // more columns pending means the block is still busy
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !last_column_o |-> busy)
    else $error("non-final column while idle");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !column_valid_o |-> last_column_o && vertical_char_o == 8'd0)
    else $error("empty alignment result malformed");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (mode_i == MODE_LOAD_V || mode_i == MODE_LOAD_H) |=> !busy)
    else $error("load transaction made the block busy");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start) && $past(mode_i) == MODE_START)
    else $error("busy without a start transaction");

endmodule

bind pairwise_sequence_alignment_top psa_checker u_psa_checker (.*);

/* sim/pairwise_sequence_alignment_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_sequence_alignment_checker
// Watches the item, configuration and result ports of the alignment block,
// keeps its own copy of the sequences and scores, computes the alignment
// columns of every start transaction and compares each emitted column with
// the oldest one still pending.
// ----------------------------------------------------------------------------
module pairwise_sequence_alignment_checker import psa_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  mode_i,
  input  logic [7:0]                  symbol_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        result_strobe_i,
  input  logic [7:0]                  vertical_char_i,
  input  logic [7:0]                  horizontal_char_i,
  input  logic                        is_match_i,
  input  logic                        column_valid_i,
  input  logic signed [ScoreOutW-1:0] total_score_i,
  input  logic                        last_column_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam int MaxLen = MaxLenDefault;
  localparam int Grid   = (MaxLen + 1) * (MaxLen + 1);

  typedef struct {
    logic [7:0]                  vch;
    logic [7:0]                  hch;
    logic                        same;
    logic                        valid;
    logic signed [ScoreOutW-1:0] score;
    logic                        last;
  } column_t;

  int              match_pts, mismatch_pts, gap_pts;
  logic            local_aln;
  logic [7:0]      vert_seq [MaxLen];
  logic [7:0]      horiz_seq [MaxLen];
  int              vert_len, horiz_len;
  int              cell_score [Grid];
  logic [1:0]      cell_step [Grid];
  column_t         pending_columns [$];

  function automatic void align_sequences();
    int      w, best, best_at, r, c, i, d, up, lf, m, n, total;
    logic    eq;
    column_t col;
    column_t traced [$];
    w = horiz_len + 1;
    best = 0;
    best_at = 0;
    for (r = 0; r <= vert_len; r++) begin
      for (c = 0; c <= horiz_len; c++) begin
        i = r * w + c;
        if (r == 0 || c == 0) begin
          if (local_aln) begin
            cell_score[i] = 0;
            cell_step[i] = PTR_STOP;
          end else begin
            cell_score[i] = gap_pts * (r + c);
            cell_step[i] = (r == 0) ? ((c == 0) ? PTR_STOP : PTR_LEFT) : PTR_UP;
          end
        end else begin
          eq = vert_seq[r-1] == horiz_seq[c-1];
          d = cell_score[i-w-1] + (eq ? match_pts : mismatch_pts);
          up = cell_score[i-w] + gap_pts;
          lf = cell_score[i-1] + gap_pts;
          m = d;
          if (up > m) m = up;
          if (lf > m) m = lf;
          if (local_aln && m < 0) m = 0;
          cell_score[i] = m;
          if (local_aln && m == 0) cell_step[i] = PTR_STOP;
          else if (d == m) cell_step[i] = PTR_DIAG;
          else if (up == m) cell_step[i] = PTR_UP;
          else cell_step[i] = PTR_LEFT;
          if (local_aln && m > best) begin
            best = m;
            best_at = i;
          end
        end
      end
    end
    if (!local_aln) best_at = (vert_len + 1) * w - 1;
    total = cell_score[best_at];
    if (total > 8191) total = 8191;
    if (total < -8192) total = -8192;

    // walk back from the best cell (local) or the last cell (global), columns come out last first
    i = best_at;
    n = 0;
    while (i > 0 && n < 2 * MaxLen) begin
      r = i / w;
      c = i % w;
      if (cell_step[i] == PTR_DIAG && r > 0 && c > 0) begin
        col.vch = vert_seq[r-1];
        col.hch = horiz_seq[c-1];
        col.same = col.vch == col.hch;
        i -= w + 1;
      end else if (cell_step[i] == PTR_LEFT && c > 0) begin
        col.vch = GAP_CHAR;
        col.hch = horiz_seq[c-1];
        col.same = 1'b0;
        i -= 1;
      end else if (cell_step[i] == PTR_UP && r > 0) begin
        col.vch = vert_seq[r-1];
        col.hch = GAP_CHAR;
        col.same = 1'b0;
        i -= w;
      end else begin
        break;
      end
      col.valid = 1'b1;
      col.score = total[ScoreOutW-1:0];
      col.last = 1'b0;
      traced.push_front(col);
      n++;
    end
    if (n == 0) begin
      col.vch = '0;
      col.hch = '0;
      col.same = 1'b0;
      col.valid = 1'b0;
      col.score = total[ScoreOutW-1:0];
      traced.insert(traced.size(), col);
    end
    traced[traced.size()-1].last = 1'b1;
    foreach (traced[k]) pending_columns.insert(pending_columns.size(), traced[k]);
    vert_len = 0;
    horiz_len = 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    column_t want;
    if (!rst_ni) begin
      match_pts = 1;
      mismatch_pts = -1;
      gap_pts = -2;
      local_aln = 1'b0;
      vert_len = 0;
      horiz_len = 0;
      fail_count_o = 0;
      pending_columns.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MATCH:    match_pts = $signed(cfg_data_i);
          CFG_MISMATCH: mismatch_pts = $signed(cfg_data_i);
          CFG_GAP:      gap_pts = $signed(cfg_data_i);
          CFG_LOCAL:    local_aln = cfg_data_i[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (mode_i)
          MODE_LOAD_V: if (vert_len < MaxLen) vert_seq[vert_len++] = symbol_i;
          MODE_LOAD_H: if (horiz_len < MaxLen) horiz_seq[horiz_len++] = symbol_i;
          MODE_START:  align_sequences();
          default: ;
        endcase
      end
      if (result_strobe_i) begin
        if (pending_columns.size() == 0) begin
          fail_count_o++;
          $display("%0t: column with nothing pending: v=%0d h=%0d score=%0d", $time,
                   vertical_char_i, horizontal_char_i, total_score_i);
        end else begin
          want = pending_columns.pop_front();
          if (want.vch !== vertical_char_i || want.hch !== horizontal_char_i ||
              want.same !== is_match_i || want.valid !== column_valid_i ||
              want.score !== total_score_i || want.last !== last_column_i) begin
            fail_count_o++;
            $display("%0t: expected v=%0d h=%0d m=%0d ok=%0d s=%0d l=%0d", $time,
                     want.vch, want.hch, want.same, want.valid, want.score, want.last);
            $display("%0t: actual   v=%0d h=%0d m=%0d ok=%0d s=%0d l=%0d", $time,
                     vertical_char_i, horizontal_char_i, is_match_i, column_valid_i,
                     total_score_i, last_column_i);
          end
        end
      end
    end
    pending_o = pending_columns.size();
  end

endmodule

/* sim/tb_pairwise_sequence_alignment_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pairwise_sequence_alignment_top
// Drives symbol loads, alignment starts and score settings into the block
// with random gaps; the checker beside it predicts and compares every column.
// ----------------------------------------------------------------------------
module tb_pairwise_sequence_alignment_top import psa_pkg::*;;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  mode_i = MODE_LOAD_V;
  logic [7:0]                  symbol_i = '0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [1:0]                  cfg_index_i = CFG_MATCH;
  logic [7:0]                  cfg_data_i = '0;
  logic                        result_strobe_o;
  logic [7:0]                  vertical_char_o;
  logic [7:0]                  horizontal_char_o;
  logic                        is_match_o;
  logic                        column_valid_o;
  logic signed [ScoreOutW-1:0] total_score_o;
  logic                        last_column_o;
  int                          fail_count;
  int                          pending;
  int                          items_sent = 0;
  logic                        steady = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pairwise_sequence_alignment_top dut (.*);

  pairwise_sequence_alignment_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .symbol_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .result_strobe_i(result_strobe_o), .vertical_char_i(vertical_char_o),
    .horizontal_char_i(horizontal_char_o), .is_match_i(is_match_o),
    .column_valid_i(column_valid_o), .total_score_i(total_score_o),
    .last_column_i(last_column_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // start stays high across back-to-back transactions
  task automatic send_item(input logic [1:0] mode, input logic [7:0] sym);
    int gap;
    int pick;
    pick = $urandom_range(99);
    gap = (steady || pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    mode_i <= mode;
    symbol_i <= sym;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] m, input logic [7:0] mm,
                            input logic [7:0] g, input logic l);
    logic [7:0] vals [4];
    vals = '{m, mm, g, {7'd0, l}};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= k[1:0];
      cfg_data_i <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_score();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 8'h7f;
    if (p == 1) return 8'h80;
    if (p < 5) return 8'($signed($urandom_range(0, 8)) - 4);
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_symbol(input logic narrow);
    logic [7:0] dna [4] = '{8'd65, 8'd67, 8'd71, 8'd84};
    return narrow ? dna[$urandom_range(3)] : 8'($urandom);
  endfunction

  // one alignment: vertical and horizontal loads interleaved, then start
  task automatic run_alignment();
    int         vl, hl, vi, hi;
    logic       narrow;
    logic [7:0] vsym [34];
    vl = ($urandom_range(19) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 8);
    hl = ($urandom_range(19) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 8);
    narrow = $urandom_range(9) < 7;
    vi = 0;
    hi = 0;
    while (vi < vl || hi < hl) begin
      if ($urandom_range(49) == 0) send_item(MODE_UNUSED, 8'($urandom));
      if (hi >= hl || (vi < vl && $urandom_range(1))) begin
        vsym[vi] = pick_symbol(narrow);
        send_item(MODE_LOAD_V, vsym[vi]);
        vi++;
      end else begin
        // mostly a mutated copy of the vertical sequence so paths run long
        if (hi < vi && $urandom_range(3) != 0) send_item(MODE_LOAD_H, vsym[hi]);
        else send_item(MODE_LOAD_H, pick_symbol(narrow));
        hi++;
      end
    end
    send_item(MODE_START, 8'($urandom));
  endtask

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // defaults: empty, single mismatch, unused mode, bit extremes
    send_item(MODE_START, 8'h00);
    send_item(MODE_LOAD_V, 8'h00);
    send_item(MODE_LOAD_H, 8'hff);
    send_item(MODE_START, 8'hff);
    send_item(MODE_UNUSED, 8'haa);
    send_item(MODE_LOAD_V, 8'hff);
    send_item(MODE_LOAD_V, 8'h00);
    send_item(MODE_LOAD_H, 8'hff);
    send_item(MODE_START, 8'h00);
    settle();
    // local with no positive cell gives the empty result; a single match follows
    write_regs(8'h7f, 8'h80, 8'h80, 1'b1);
    send_item(MODE_LOAD_V, 8'd65);
    send_item(MODE_LOAD_H, 8'd66);
    send_item(MODE_START, 8'h00);
    send_item(MODE_LOAD_V, 8'd65);
    send_item(MODE_LOAD_H, 8'd65);
    send_item(MODE_START, 8'h00);
    settle();
    write_regs(8'h80, 8'h7f, 8'h7f, 1'b0);
    send_item(MODE_LOAD_V, 8'd1);
    send_item(MODE_LOAD_V, 8'd2);
    send_item(MODE_LOAD_H, 8'd2);
    send_item(MODE_START, 8'h00);
    settle();

    while (items_sent < 500) begin
      write_regs(pick_score(), pick_score(), pick_score(), 1'($urandom));
      steady = $urandom_range(4) == 0;
      repeat ($urandom_range(2, 6)) run_alignment();
      settle();
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/psa_pkg.sv
hw/rtl/psa_ctrl.sv
hw/rtl/psa_dp.sv
hw/rtl/pairwise_sequence_alignment_top.sv
hw/rtl/psa_checker.sv
sim/pairwise_sequence_alignment_checker.sv
sim/tb_pairwise_sequence_alignment_top.sv
